// ===== hdl/mcp_pkg.sv =====
// Shared types, constants and prime table of the coarsening planner.
`timescale 1ns / 1ps
`default_nettype none
package mcp_pkg;

	localparam int unsigned AXES       = 3;
	localparam int unsigned TINY_SIZE  = 6;
	localparam int unsigned PRIME_IDX_W = 6;
	localparam int unsigned PRIME_W    = 8;
	localparam int unsigned LVL_W      = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PRIME_ST,
		ST_PRIME_WT,
		ST_ADJ_NEXT,
		ST_ADJ_WT,
		ST_SHR_ST,
		ST_SHR_WT,
		ST_DONE
	} mcp_state_t;

	typedef logic [PRIME_W-1:0] prime_t;

	localparam prime_t PRIMES [40] = '{
		8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
		8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71,
		8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
		8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd173
	};

	function automatic prime_t prime_at(input logic [PRIME_IDX_W-1:0] k);
		prime_t p;
		p = 8'd173;
		if (k < 6'd40) begin
			p = PRIMES[k];
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mcp_if.sv =====
// Handshake channels for grid descriptions and plan results.
`timescale 1ns / 1ps
`default_nettype none
interface mcp_in_if #(parameter int unsigned SIZE_BITS = 25);
	logic                 valid;
	logic                 ready;
	logic [1:0]           dims;
	logic [SIZE_BITS-1:0] size_x;
	logic [SIZE_BITS-1:0] size_y;
	logic [SIZE_BITS-1:0] size_z;
	logic [15:0]          procs_x;
	logic [15:0]          procs_y;
	logic [15:0]          procs_z;
	logic                 periodic_x;
	logic                 periodic_y;
	logic                 periodic_z;
	modport source (output valid, dims, size_x, size_y, size_z, procs_x, procs_y, procs_z,
		periodic_x, periodic_y, periodic_z, input ready);
	modport sink (input valid, dims, size_x, size_y, size_z, procs_x, procs_y, procs_z,
		periodic_x, periodic_y, periodic_z, output ready);
endinterface

interface mcp_out_if #(parameter int unsigned SIZE_BITS = 25);
	logic                 valid;
	logic                 ready;
	logic                 can_coarsen;
	logic [SIZE_BITS-1:0] factor_x;
	logic [SIZE_BITS-1:0] factor_y;
	logic [SIZE_BITS-1:0] factor_z;
	logic [6:0]           level_count;
	modport source (output valid, can_coarsen, factor_x, factor_y, factor_z, level_count,
		input ready);
	modport sink (input valid, can_coarsen, factor_x, factor_y, factor_z, level_count,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/mcp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mcp_div #(
	parameter int unsigned W = 25
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    trial;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q[W-1:0];
endmodule
`default_nettype wire

// ===== hdl/multigrid_coarsening_planner_core.sv =====
// Top level of the multigrid coarsening planner: sequencer around a shared divider.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   in_ch  : one grid description per item (dims, sizes, process counts, periodic flags).
//   out_ch : one plan per item (can_coarsen, first-level factors, level_count).
//   in_ch.ready is high only while the sequencer is idle; one item is planned at a time.
// Divisions
//   Every division (prime test, size/factor compare, size reduction) runs on a single
//   shared restoring divider. Per level: up to dims*NUM_PRIMES prime tests, up to
//   dims*(dims-1) compares and dims reductions. Small primes usually hit early, so
//   an item needs far fewer divisions than the worst case. The divider sets the pace.
// Output
//   The result sits in an output register. A new item may be accepted while it waits;
//   the next result is held in the sequencer until out_ch.ready frees the register.
// Reset
//   arst_n clears the sequencer and output valid; no store needs clearing.
module multigrid_coarsening_planner_core #(
	parameter int unsigned MAX_LEVELS = 64,
	parameter int unsigned NUM_PRIMES = 40,
	parameter int unsigned SIZE_BITS  = 25
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mcp_in_if.sink    in_ch,
	mcp_out_if.source out_ch
);
	import mcp_pkg::*;

	localparam int unsigned W = SIZE_BITS;

	mcp_state_t state_q, state_d;

	logic [W-1:0]       w_q [AXES];   // working sizes of the current level
	logic [15:0]        p_q [AXES];
	logic [W-1:0]       g_q [AXES];   // factors of the current level
	logic [W-1:0]       f0_q [AXES];  // first-level factors
	logic               ok_q;
	logic               first_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [1:0]         nd_q;
	logic [1:0]         ax_q;
	logic [1:0]         jx_q;
	logic [PRIME_IDX_W-1:0] k_q;

	logic               out_valid_q;
	logic               out_ok_q;
	logic [W-1:0]       out_f_q [AXES];
	logic [LVL_W-1:0]   out_lvl_q;

	// divider
	logic               div_start;
	logic [W-1:0]       div_a, div_b;
	logic               div_done;
	logic [W-1:0]       div_q, div_r;

	mcp_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	// stop test of a level on the working sizes
	logic any_zero, all_one, all_tiny, proc_stop, stop;
	always_comb begin
		any_zero  = 1'b0;
		all_one   = 1'b1;
		all_tiny  = 1'b1;
		proc_stop = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			if (w_q[i] == '0) any_zero = 1'b1;
			if (w_q[i] != W'(1)) all_one = 1'b0;
			if (w_q[i] > W'(TINY_SIZE)) all_tiny = 1'b0;
			if ((2'(i) < nd_q) && ({{(32-W){1'b0}}, w_q[i]} <= {16'd0, p_q[i]}))
				proc_stop = 1'b1;
		end
		stop = any_zero || all_one || all_tiny || proc_stop;
	end

	logic last_ax;
	assign last_ax = (ax_q == nd_q - 2'd1);

	// next state and divider issue
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_a     = w_q[ax_q];
		div_b     = W'(prime_at(k_q));
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stop || (!first_q && lvl_q == LVL_W'(MAX_LEVELS))) state_d = ST_DONE;
				else state_d = ST_PRIME_ST;
			end
			ST_PRIME_ST: begin
				div_start = 1'b1;
				state_d   = ST_PRIME_WT;
			end
			ST_PRIME_WT: begin
				if (div_done) begin
					if (div_r == '0 || k_q == PRIME_IDX_W'(NUM_PRIMES - 1))
						state_d = last_ax ? ST_ADJ_NEXT : ST_PRIME_ST;
					else
						state_d = ST_PRIME_ST;
				end
			end
			ST_ADJ_NEXT: begin
				div_a = w_q[jx_q];
				div_b = g_q[jx_q];
				if (ax_q >= nd_q) state_d = ST_SHR_ST;
				else if (g_q[ax_q] != W'(1) && jx_q < nd_q && jx_q != ax_q) begin
					div_start = 1'b1;
					state_d   = ST_ADJ_WT;
				end
			end
			ST_ADJ_WT: begin
				if (div_done) state_d = ST_ADJ_NEXT;
			end
			ST_SHR_ST: begin
				div_b     = g_q[ax_q];
				div_start = 1'b1;
				state_d   = ST_SHR_WT;
			end
			ST_SHR_WT: begin
				if (div_done) state_d = last_ax ? ST_CHECK : ST_SHR_ST;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// sequencer counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			ax_q    <= '0;
			jx_q    <= '0;
			k_q     <= '0;
			lvl_q   <= '0;
			nd_q    <= 2'd1;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						first_q <= 1'b1;
						lvl_q   <= LVL_W'(1);
						nd_q    <= (in_ch.dims == 2'd0) ? 2'd1 : in_ch.dims;
					end
				end
				ST_CHECK: begin
					ax_q <= '0;
					k_q  <= '0;
					if (stop && first_q) ok_q <= 1'b0;
				end
				ST_PRIME_WT: begin
					if (div_done) begin
						if (div_r == '0 || k_q == PRIME_IDX_W'(NUM_PRIMES - 1)) begin
							k_q  <= '0;
							ax_q <= last_ax ? 2'd0 : ax_q + 2'd1;
							jx_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_ADJ_NEXT: begin
					if (ax_q >= nd_q) begin
						ax_q <= '0;
						if (first_q) begin
							ok_q    <= 1'b1;
							first_q <= 1'b0;
						end
					end else if (g_q[ax_q] == W'(1) || jx_q >= nd_q) begin
						ax_q <= ax_q + 2'd1;
						jx_q <= '0;
					end else if (jx_q == ax_q) begin
						jx_q <= jx_q + 2'd1;
					end
				end
				ST_ADJ_WT: begin
					if (div_done) jx_q <= jx_q + 2'd1;
				end
				ST_SHR_WT: begin
					if (div_done) begin
						ax_q <= ax_q + 2'd1;
						if (last_ax) lvl_q <= lvl_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// working sizes and factors
	logic [W-1:0] sz_in [AXES];
	logic [15:0]  pr_in [AXES];
	logic         per_in [AXES];
	assign sz_in  = '{in_ch.size_x, in_ch.size_y, in_ch.size_z};
	assign pr_in  = '{in_ch.procs_x, in_ch.procs_y, in_ch.procs_z};
	assign per_in = '{in_ch.periodic_x, in_ch.periodic_y, in_ch.periodic_z};

	logic [1:0] nd_in;
	assign nd_in = (in_ch.dims == 2'd0) ? 2'd1 : in_ch.dims;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < AXES; i++) begin
					if (2'(i) < nd_in) begin
						w_q[i] <= (!per_in[i] && sz_in[i] != '0) ? sz_in[i] - W'(1) : sz_in[i];
						p_q[i] <= pr_in[i];
					end else begin
						w_q[i] <= W'(1);
						p_q[i] <= 16'd1;
					end
				end
			end
			ST_CHECK: begin
				for (int i = 0; i < AXES; i++) begin
					g_q[i] <= (2'(i) < nd_q) ? w_q[i] : W'(1);
					if (stop && first_q) f0_q[i] <= (2'(i) < nd_q) ? w_q[i] : W'(1);
				end
			end
			ST_PRIME_WT: begin
				if (div_done) begin
					if (div_r == '0) g_q[ax_q] <= W'(prime_at(k_q));
					else if (k_q == PRIME_IDX_W'(NUM_PRIMES - 1)) g_q[ax_q] <= w_q[ax_q];
				end
			end
			ST_ADJ_NEXT: begin
				if (ax_q >= nd_q && first_q) f0_q <= g_q;
			end
			ST_ADJ_WT: begin
				if (div_done && w_q[ax_q] <= div_q) g_q[ax_q] <= W'(1);
			end
			ST_SHR_WT: begin
				if (div_done) w_q[ax_q] <= div_q;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
			out_ok_q  <= ok_q;
			out_f_q   <= f0_q;
			out_lvl_q <= lvl_q;
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.can_coarsen = out_ok_q;
	assign out_ch.factor_x    = out_f_q[0];
	assign out_ch.factor_y    = out_f_q[1];
	assign out_ch.factor_z    = out_f_q[2];
	assign out_ch.level_count = out_lvl_q;
endmodule
`default_nettype wire

// ===== hdl/mcp_checker.sv =====
// Port-level checks of the planner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mcp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       can_coarsen,
	input wire logic [6:0] level_count
);
	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// planning takes time: no input accepted right after one was
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// a failed first step means a single level
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !can_coarsen |-> level_count == 7'd1)
		else $error("levels without coarsening");

	// a successful first step adds at least one level
	a_multi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && can_coarsen |-> level_count >= 7'd2)
		else $error("coarsening without extra level");
endmodule

bind multigrid_coarsening_planner_core mcp_checker u_mcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.can_coarsen (out_ch.can_coarsen),
	.level_count (out_ch.level_count)
);
`default_nettype wire
